// ===== rtl/core/tpq_pkg.sv =====
// Package for the tracker period-to-note quantizer.
// Holds the finetune period table, the controller state type and the
// command and status structs that join the controller and the datapath.
package tpq_pkg;

	localparam int NOTE_COUNT       = 96;
	localparam int NOTES_PER_OCTAVE = 12;
	localparam int ROW_COUNT        = 16;
	localparam int PERIOD_W         = 13;
	localparam int NOTE_W           = 7;
	localparam int ROW_W            = 4;
	localparam int COL_W            = 4;
	localparam int OCT_W            = 3;

	localparam logic [NOTE_W-1:0] NOTE_LAST = NOTE_W'(NOTE_COUNT - 1);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(NOTES_PER_OCTAVE - 1);

	localparam logic [PERIOD_W-1:0] PERIOD_ROWS [0:ROW_COUNT-1][0:NOTES_PER_OCTAVE-1] = '{
		'{13'd6848, 13'd6464, 13'd6096, 13'd5760, 13'd5424, 13'd5120,
		  13'd4832, 13'd4560, 13'd4304, 13'd4064, 13'd3840, 13'd3624},
		'{13'd6800, 13'd6416, 13'd6056, 13'd5720, 13'd5392, 13'd5096,
		  13'd4808, 13'd4536, 13'd4280, 13'd4040, 13'd3816, 13'd3600},
		'{13'd6752, 13'd6368, 13'd6016, 13'd5672, 13'd5360, 13'd5056,
		  13'd4776, 13'd4504, 13'd4256, 13'd4016, 13'd3792, 13'd3576},
		'{13'd6704, 13'd6328, 13'd5968, 13'd5632, 13'd5320, 13'd5024,
		  13'd4736, 13'd4472, 13'd4224, 13'd3984, 13'd3760, 13'd3552},
		'{13'd6656, 13'd6280, 13'd5928, 13'd5592, 13'd5280, 13'd4984,
		  13'd4704, 13'd4440, 13'd4192, 13'd3960, 13'd3736, 13'd3528},
		'{13'd6608, 13'd6232, 13'd5888, 13'd5552, 13'd5240, 13'd4952,
		  13'd4672, 13'd4408, 13'd4160, 13'd3928, 13'd3704, 13'd3496},
		'{13'd6560, 13'd6192, 13'd5840, 13'd5512, 13'd5208, 13'd4912,
		  13'd4640, 13'd4376, 13'd4128, 13'd3896, 13'd3680, 13'd3472},
		'{13'd6512, 13'd6144, 13'd5800, 13'd5472, 13'd5168, 13'd4880,
		  13'd4600, 13'd4344, 13'd4104, 13'd3872, 13'd3656, 13'd3448},
		'{13'd7256, 13'd6848, 13'd6464, 13'd6096, 13'd5760, 13'd5424,
		  13'd5120, 13'd4832, 13'd4560, 13'd4304, 13'd4032, 13'd3840},
		'{13'd7200, 13'd6800, 13'd6416, 13'd6056, 13'd5720, 13'd5400,
		  13'd5088, 13'd4808, 13'd4536, 13'd4280, 13'd4040, 13'd3816},
		'{13'd7152, 13'd6752, 13'd6368, 13'd6016, 13'd5672, 13'd5360,
		  13'd5056, 13'd4776, 13'd4504, 13'd4256, 13'd4016, 13'd3792},
		'{13'd7096, 13'd6704, 13'd6328, 13'd5968, 13'd5632, 13'd5320,
		  13'd5024, 13'd4736, 13'd4472, 13'd4224, 13'd3984, 13'd3760},
		'{13'd7048, 13'd6656, 13'd6280, 13'd5928, 13'd5592, 13'd5280,
		  13'd4984, 13'd4704, 13'd4440, 13'd4192, 13'd3952, 13'd3736},
		'{13'd7000, 13'd6608, 13'd6232, 13'd5888, 13'd5552, 13'd5240,
		  13'd4952, 13'd4672, 13'd4408, 13'd4160, 13'd3928, 13'd3704},
		'{13'd6944, 13'd6560, 13'd6192, 13'd5840, 13'd5512, 13'd5208,
		  13'd4912, 13'd4640, 13'd4376, 13'd4128, 13'd3896, 13'd3680},
		'{13'd6896, 13'd6512, 13'd6144, 13'd5800, 13'd5472, 13'd5168,
		  13'd4880, 13'd4600, 13'd4344, 13'd4104, 13'd3872, 13'd3656}
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} tpq_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic load_out;
	} tpq_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic last;
	} tpq_sts_t;

endpackage

// ===== rtl/core/tracker_period_to_note_quantizer.sv =====
// Top level of the tracker period-to-note quantizer.
// The scan compares one table note per cycle over 96 notes; a zero period skips it
// and goes straight to the result. A new beat is taken only after the last result
// is loaded, and may be taken while that result waits.
// Reset: arst_n clears the controller state and the result valid flag only.
module tracker_period_to_note_quantizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [tpq_pkg::PERIOD_W-1:0]  period,
	input  logic [tpq_pkg::ROW_W-1:0]     fine_tune,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [tpq_pkg::NOTE_W-1:0]    note,
	output logic [tpq_pkg::PERIOD_W-1:0]  snapped_period
);

	tpq_pkg::tpq_cmd_t cmd;
	tpq_pkg::tpq_sts_t sts;

	tpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	tpq_datapath u_datapath (
		.clk            (clk),
		.period         (period),
		.fine_tune      (fine_tune),
		.cmd            (cmd),
		.sts            (sts),
		.note           (note),
		.snapped_period (snapped_period)
	);

endmodule

// ===== rtl/core/tpq_datapath.sv =====
// Datapath of the tracker period-to-note quantizer.
// Walks the notes of one period table row, tracks the nearest one and holds
// the result registers. Depends on tpq_pkg.
module tpq_datapath (
	input  logic                          clk,
	input  logic [tpq_pkg::PERIOD_W-1:0]  period,
	input  logic [tpq_pkg::ROW_W-1:0]     fine_tune,
	input  tpq_pkg::tpq_cmd_t             cmd,
	output tpq_pkg::tpq_sts_t             sts,
	output logic [tpq_pkg::NOTE_W-1:0]    note,
	output logic [tpq_pkg::PERIOD_W-1:0]  snapped_period
);

	logic [tpq_pkg::PERIOD_W-1:0] period_q;
	logic [tpq_pkg::ROW_W-1:0]    row_q;
	logic                         zero_q;
	logic [tpq_pkg::COL_W-1:0]    col_q;
	logic [tpq_pkg::OCT_W-1:0]    oct_q;
	logic [tpq_pkg::NOTE_W-1:0]   k_q;
	logic [tpq_pkg::NOTE_W-1:0]   best_k_q;
	logic [tpq_pkg::PERIOD_W-1:0] best_p_q;
	logic [tpq_pkg::PERIOD_W-1:0] best_d_q;
	logic [tpq_pkg::NOTE_W-1:0]   note_q;
	logic [tpq_pkg::PERIOD_W-1:0] snapped_q;

	logic [tpq_pkg::PERIOD_W-1:0] cand_p;
	logic [tpq_pkg::PERIOD_W-1:0] cand_d;
	logic                         take;

	always_comb begin
		cand_p = tpq_pkg::PERIOD_ROWS[row_q][col_q] >> oct_q;
		if (period_q >= cand_p) begin
			cand_d = period_q - cand_p;
		end else begin
			cand_d = cand_p - period_q;
		end
		take = (k_q == '0) || (cand_d < best_d_q);
	end

	assign sts.in_zero = (period == '0);
	assign sts.last    = (k_q == tpq_pkg::NOTE_LAST);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			period_q <= period;
			row_q    <= fine_tune;
			zero_q   <= (period == '0);
			col_q    <= '0;
			oct_q    <= '0;
			k_q      <= '0;
		end else if (cmd.step) begin
			if (take) begin
				best_k_q <= k_q;
				best_p_q <= cand_p;
				best_d_q <= cand_d;
			end
			k_q <= k_q + tpq_pkg::NOTE_W'(1);
			if (col_q == tpq_pkg::COL_LAST) begin
				col_q <= '0;
				oct_q <= oct_q + tpq_pkg::OCT_W'(1);
			end else begin
				col_q <= col_q + tpq_pkg::COL_W'(1);
			end
		end
		if (cmd.load_out) begin
			if (zero_q) begin
				note_q    <= '0;
				snapped_q <= '0;
			end else begin
				note_q    <= best_k_q + tpq_pkg::NOTE_W'(1);
				snapped_q <= best_p_q;
			end
		end
	end

	assign note           = note_q;
	assign snapped_period = snapped_q;

endmodule

// ===== rtl/core/tpq_ctrl.sv =====
// Controller of the tracker period-to-note quantizer.
// Sequences accept, note scan and result hand-off; owns the result valid
// flag. Depends on tpq_pkg.
module tpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  tpq_pkg::tpq_sts_t  sts,
	output tpq_pkg::tpq_cmd_t  cmd
);

	tpq_pkg::tpq_state_t state_q;
	tpq_pkg::tpq_state_t state_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		item_stall   = 1'b1;
		case (state_q)
			tpq_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.start = 1'b1;
					state_d   = sts.in_zero ? tpq_pkg::ST_FINISH : tpq_pkg::ST_SCAN;
				end
			end
			tpq_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = tpq_pkg::ST_FINISH;
				end
			end
			tpq_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = tpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpq_pkg::ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpq_pkg::ST_SCAN && sts.last) |=> (state_q == tpq_pkg::ST_FINISH))
		else $error("scan did not end after the last note");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> result_valid)
		else $error("loaded result is not offered");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && out_valid_q) |-> !result_stall)
		else $error("result register overwritten while stalled");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> item_stall)
		else $error("new beat taken during a scan");

endmodule

// ===== bench/tracker_period_to_note_quantizer_checker.sv =====
// Checker for the tracker period-to-note quantizer testbench.
// Watches the input and result channels, predicts each note from its own period grid
// and compares it with the block's result; depends on tpq_pkg for port widths.
`timescale 1ns / 1ps

module tracker_period_to_note_quantizer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic [tpq_pkg::PERIOD_W-1:0]  period,
	input  logic [tpq_pkg::ROW_W-1:0]     fine_tune,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [tpq_pkg::NOTE_W-1:0]    note,
	input  logic [tpq_pkg::PERIOD_W-1:0]  snapped_period,
	output int                            failures,
	output int                            pending,
	output int                            checked
);

	typedef struct packed {
		logic [tpq_pkg::NOTE_W-1:0]   note;
		logic [tpq_pkg::PERIOD_W-1:0] snapped;
	} note_guess_t;

	localparam logic [12:0] PERIOD_GRID [0:15][0:11] = '{
		'{6848, 6464, 6096, 5760, 5424, 5120, 4832, 4560, 4304, 4064, 3840, 3624},
		'{6800, 6416, 6056, 5720, 5392, 5096, 4808, 4536, 4280, 4040, 3816, 3600},
		'{6752, 6368, 6016, 5672, 5360, 5056, 4776, 4504, 4256, 4016, 3792, 3576},
		'{6704, 6328, 5968, 5632, 5320, 5024, 4736, 4472, 4224, 3984, 3760, 3552},
		'{6656, 6280, 5928, 5592, 5280, 4984, 4704, 4440, 4192, 3960, 3736, 3528},
		'{6608, 6232, 5888, 5552, 5240, 4952, 4672, 4408, 4160, 3928, 3704, 3496},
		'{6560, 6192, 5840, 5512, 5208, 4912, 4640, 4376, 4128, 3896, 3680, 3472},
		'{6512, 6144, 5800, 5472, 5168, 4880, 4600, 4344, 4104, 3872, 3656, 3448},
		'{7256, 6848, 6464, 6096, 5760, 5424, 5120, 4832, 4560, 4304, 4032, 3840},
		'{7200, 6800, 6416, 6056, 5720, 5400, 5088, 4808, 4536, 4280, 4040, 3816},
		'{7152, 6752, 6368, 6016, 5672, 5360, 5056, 4776, 4504, 4256, 4016, 3792},
		'{7096, 6704, 6328, 5968, 5632, 5320, 5024, 4736, 4472, 4224, 3984, 3760},
		'{7048, 6656, 6280, 5928, 5592, 5280, 4984, 4704, 4440, 4192, 3952, 3736},
		'{7000, 6608, 6232, 5888, 5552, 5240, 4952, 4672, 4408, 4160, 3928, 3704},
		'{6944, 6560, 6192, 5840, 5512, 5208, 4912, 4640, 4376, 4128, 3896, 3680},
		'{6896, 6512, 6144, 5800, 5472, 5168, 4880, 4600, 4344, 4104, 3872, 3656}
	};

	note_guess_t expected_notes [$];
	int fail_count = 0;
	int check_count = 0;
	int pend_count = 0;

	assign failures = fail_count;
	assign checked  = check_count;
	assign pending  = pend_count;

	function automatic note_guess_t quantize_period(logic [12:0] p, logic [3:0] row);
		note_guess_t  guess;
		int unsigned  cand;
		int unsigned  gap;
		int unsigned  best_gap;
		guess = '0;
		if (p == '0)
			return guess;
		best_gap = 32'hFFFF_FFFF;
		for (int k = 0; k < 96; k++) begin
			cand = PERIOD_GRID[row][k % 12] >> (k / 12);
			gap  = (p >= cand) ? p - cand : cand - p;
			if (gap < best_gap) begin
				best_gap      = gap;
				guess.note    = 7'(k + 1);
				guess.snapped = 13'(cand);
			end
		end
		return guess;
	endfunction

	always @(posedge clk) begin
		note_guess_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_notes.size() == 0) begin
					$error("result beat with nothing expected: note %0d snapped_period %0d",
						note, snapped_period);
					fail_count++;
				end else begin
					want = expected_notes.pop_front();
					check_count++;
					if (note !== want.note) begin
						$error("note: expected %0d, got %0d", want.note, note);
						fail_count++;
					end
					if (snapped_period !== want.snapped) begin
						$error("snapped_period: expected %0d, got %0d", want.snapped,
							snapped_period);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				expected_notes = {expected_notes, quantize_period(period, fine_tune)};
			pend_count <= expected_notes.size();
		end
	end

endmodule

// ===== bench/tracker_period_to_note_quantizer_tb.sv =====
// Top of the tracker period-to-note quantizer testbench.
// Drives directed and random period beats with random idling on both channels and
// gives the verdict; depends on the block, its package and the checker module.
`timescale 1ns / 1ps

module tracker_period_to_note_quantizer_tb;

	localparam int RANDOM_BEATS = 2000;
	localparam int QUIET_TAIL   = 200;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          item_valid = 1'b0;
	logic                          item_stall;
	logic [tpq_pkg::PERIOD_W-1:0]  period = '0;
	logic [tpq_pkg::ROW_W-1:0]     fine_tune = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [tpq_pkg::NOTE_W-1:0]    note;
	logic [tpq_pkg::PERIOD_W-1:0]  snapped_period;

	int  failures;
	int  pending;
	int  checked;
	int  cycle_count = 0;
	int  beats_sent = 0;
	int  zero_beats = 0;
	bit  idle_en = 1'b0;
	bit  hold_req = 1'b0;

	tracker_period_to_note_quantizer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.period         (period),
		.fine_tune      (fine_tune),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.note           (note),
		.snapped_period (snapped_period)
	);

	tracker_period_to_note_quantizer_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.period         (period),
		.fine_tune      (fine_tune),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.note           (note),
		.snapped_period (snapped_period),
		.failures       (failures),
		.pending        (pending),
		.checked        (checked)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results pending.", cycle_count,
				pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver stalls in short random bursts, or for one long stretch on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_beat(input logic [12:0] p, input logic [3:0] row);
		period     <= p;
		fine_tune  <= row;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		beats_sent++;
		if (p == '0)
			zero_beats++;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [12:0] pick_period(input logic [3:0] row);
		int           sel;
		int           k;
		int           k2;
		int           v;
		int unsigned  a;
		int unsigned  b;
		sel = $urandom_range(0, 99);
		k   = $urandom_range(0, 95);
		a   = tpq_pkg::PERIOD_ROWS[row][k % 12] >> (k / 12);
		if (sel < 8)
			return '0;
		if (sel < 30) begin
			v = int'(a) + int'($urandom_range(0, 4)) - 2;
			return 13'((v < 0) ? 0 : v);
		end
		if (sel < 42) begin
			k2 = (k < 95) ? k + 1 : k - 1;
			b  = tpq_pkg::PERIOD_ROWS[row][k2 % 12] >> (k2 / 12);
			return 13'((a + b) / 2);
		end
		if (sel < 80)
			return 13'($urandom_range(1, 7400));
		return 13'($urandom_range(0, 8191));
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero periods, both period extremes, exact entries, ties and bit patterns.
		send_beat(13'd0, 4'd0);
		send_beat(13'd0, 4'd15);
		send_beat(13'd8191, 4'd0);
		send_beat(13'd8191, 4'd8);
		send_beat(13'd8191, 4'd15);
		send_beat(13'd1, 4'd0);
		send_beat(13'd1, 4'd15);
		send_beat(13'd6848, 4'd0);
		send_beat(13'd7256, 4'd8);
		send_beat(13'd7257, 4'd8);
		send_beat(13'd6656, 4'd0);
		send_beat(13'd46, 4'd0);
		send_beat(13'd3732, 4'd0);
		send_beat(13'd28, 4'd0);
		send_beat(13'h1555, 4'd5);
		send_beat(13'h0AAA, 4'd10);
		send_beat(13'd0, 4'd7);
		send_beat(13'd3448, 4'd7);
		send_beat(13'd3656, 4'd15);
		send_beat(13'd0, 4'd0);
		drain_results();

		idle_en = 1'b1;
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			logic [3:0] row;
			row     = 4'($urandom_range(0, 15));
			idle_en = (i % 400 < 320) && (i < RANDOM_BEATS - QUIET_TAIL);
			if (i == 700)
				hold_req = 1'b1;
			if (i == 1200)
				drain_results();
			send_beat(pick_period(row), row);
		end
		drain_results();
		repeat (200) @(posedge clk);

		$display("Covered %0d beats (%0d with zero period) over all finetune rows;",
			beats_sent, zero_beats);
		$display("%0d results compared, with one long result hold-off and one full drain.",
			checked);
		if (failures == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
